FILE: rtl/msr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants of the MESI snoop responder
// Geometry of the L1 tag store, field encodings and address helpers.
// ----------------------------------------------------------------------------
package msr_pkg;

  // Geometry
  localparam int SET_COUNT        = 64;
  localparam int WAY_COUNT        = 4;
  localparam int LINE_OFFSET_BITS = 6;

  localparam int ADDR_W = 32;
  localparam int DATA_W = 64;
  localparam int IDX_W  = $clog2(SET_COUNT);
  localparam int TAG_W  = ADDR_W - LINE_OFFSET_BITS - IDX_W;
  localparam int WAY_W  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

  typedef logic [IDX_W-1:0]  set_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [WAY_W-1:0]  way_t;
  typedef logic [DATA_W-1:0] data_t;

  // Line states
  typedef enum logic [1:0] {
    MESI_I = 2'd0,
    MESI_S = 2'd1,
    MESI_E = 2'd2,
    MESI_M = 2'd3
  } mesi_e;

  // Item kinds
  typedef enum logic [1:0] {
    REQ_SNOOP   = 2'd0,
    REQ_INSTALL = 2'd1,
    REQ_PEND    = 2'd2
  } req_e;

  // Snooped bus commands
  typedef enum logic [1:0] {
    CMD_BUS_RD   = 2'd0,
    CMD_BUS_RDX  = 2'd1,
    CMD_BUS_UPGR = 2'd2,
    CMD_NOP      = 2'd3
  } bus_cmd_e;

  // One way of the tag store
  typedef struct packed {
    tag_t  tag;
    mesi_e mesi;
    data_t data;
  } entry_t;

  typedef entry_t [WAY_COUNT-1:0] row_t;

  // Write request into the tag store
  typedef struct packed {
    logic   en;
    set_t   set;
    way_t   way;
    entry_t entry;
    logic   valid;
  } wr_req_t;

  // Set index: index field folded into the set range (one compare and subtract,
  // since the field stays below twice the set count)
  function automatic set_t set_of(logic [ADDR_W-1:0] addr);
    set_t field;
    field = addr[LINE_OFFSET_BITS +: IDX_W];
    if (field >= IDX_W'(SET_COUNT)) begin
      return field - IDX_W'(SET_COUNT);
    end
    return field;
  endfunction

  function automatic tag_t tag_of(logic [ADDR_W-1:0] addr);
    return addr[ADDR_W-1 -: TAG_W];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/msr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msr_if: request and response channels of the MESI snoop responder
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface msr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] address;
  logic [1:0]  bus_cmd;
  logic        data_grant;
  logic [1:0]  way_sel;
  logic [1:0]  mesi_value;
  logic [63:0] write_data;
  logic        pending_on;

  modport source (
    output valid, req_type, address, bus_cmd, data_grant, way_sel, mesi_value,
           write_data, pending_on,
    input  ready
  );
  modport sink (
    input  valid, req_type, address, bus_cmd, data_grant, way_sel, mesi_value,
           write_data, pending_on,
    output ready
  );
endinterface

interface msr_rsp_if;
  logic        valid;
  logic        ready;
  logic        line_held;
  logic        has_mod;
  logic        inv_ack;
  logic        data_valid;
  logic [63:0] read_data;

  modport source (
    output valid, line_held, has_mod, inv_ack, data_valid, read_data,
    input  ready
  );
  modport sink (
    input  valid, line_held, has_mod, inv_ack, data_valid, read_data,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/msr_tag_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msr_tag_store: set-organized tag/state/data RAM with valid flops
// One row (all ways of a set) is read per cycle with registered data; one way
// is written per cycle. The last write is forwarded over the read data.
// ----------------------------------------------------------------------------
module msr_tag_store import msr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    rd_en_i,
  input  wire set_t    rd_set_i,
  input  wire set_t    look_set_i,
  input  wire wr_req_t wr_i,
  output row_t         row_o,
  output logic [WAY_COUNT-1:0] vld_o
);

  row_t                 ram [SET_COUNT];
  row_t                 row_q;
  logic [WAY_COUNT-1:0] valid_q [SET_COUNT];
  logic                 fwd_en_q;
  set_t                 fwd_set_q;
  way_t                 fwd_way_q;
  entry_t               fwd_entry_q;

  // RAM: one way written, one row read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ram[wr_i.set][wr_i.way] <= wr_i.entry;
    end
    if (rd_en_i) begin
      row_q <= ram[rd_set_i];
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SET_COUNT; s++) begin
        valid_q[s] <= '0;
      end
    end else if (wr_i.en) begin
      valid_q[wr_i.set][wr_i.way] <= wr_i.valid;
    end
  end

  // Last write, kept for read-during-write forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_en_q <= 1'b0;
    end else if (wr_i.en) begin
      fwd_en_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      fwd_set_q   <= wr_i.set;
      fwd_way_q   <= wr_i.way;
      fwd_entry_q <= wr_i.entry;
    end
  end

  // Forward the last write over stale RAM data
  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (fwd_en_q && fwd_set_q == look_set_i && fwd_way_q == WAY_W'(w)) begin
        row_o[w] = fwd_entry_q;
      end else begin
        row_o[w] = row_q[w];
      end
    end
  end

  assign vld_o = valid_q[look_set_i];

endmodule
`default_nettype wire

FILE: rtl/mesi_snoop_responder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mesi_snoop_responder: snoop side of an L1 cache with MESI states
// Answers bus snoops from a pending-miss record or the tag store.
// ----------------------------------------------------------------------------
// Every accepted word (snoop, install or pending-set) yields exactly one
// response word. The block takes one word per cycle while its responses are
// taken: the set row is read from the tag RAM at acceptance; the lookup then
// runs on the registered row, and the response and the write-back of one way
// happen together when the word leaves stage 1; the last write is forwarded so
// back-to-back words to the same set see it. The response register is loaded
// as the word leaves stage 1; a stalled response holds the pipeline.
// Valid bits live in flops, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module mesi_snoop_responder import msr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  msr_req_if.sink   req_i,
  msr_rsp_if.source rsp_o
);

  typedef struct packed {
    req_e     req_type;
    set_t     set;
    tag_t     tag;
    bus_cmd_e bus_cmd;
    logic     data_grant;
    logic [1:0] way_sel;
    mesi_e    mesi_value;
    data_t    write_data;
    logic     pending_on;
  } item_t;

  localparam logic [4:0] WAY_LIMIT = 5'(WAY_COUNT);

  logic    s1_valid_q;
  item_t   s1_q;
  logic    s1_fire;
  logic    in_fire;
  row_t    row;
  logic [WAY_COUNT-1:0] vld;
  wr_req_t wr;

  logic  pend_active_q, pend_active_d;
  set_t  pend_set_q, pend_set_d;
  tag_t  pend_tag_q, pend_tag_d;
  mesi_e pend_target_q, pend_target_d;

  logic  out_valid_q;
  logic  sh_q, mod_q, ack_q, dv_q;
  data_t rdata_q;
  logic  sh_d, mod_d, ack_d, dv_d;
  data_t rdata_d;

  logic   any_hit;
  way_t   hit_way;
  entry_t hit_entry;
  logic   pmatch;

  // Handshake
  assign s1_fire     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_fire;
  assign in_fire     = req_i.valid && req_i.ready;

  // Stage 1 item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.req_type   <= req_e'(req_i.req_type);
      s1_q.set        <= set_of(req_i.address);
      s1_q.tag        <= tag_of(req_i.address);
      s1_q.bus_cmd    <= bus_cmd_e'(req_i.bus_cmd);
      s1_q.data_grant <= req_i.data_grant;
      s1_q.way_sel    <= req_i.way_sel;
      s1_q.mesi_value <= mesi_e'(req_i.mesi_value);
      s1_q.write_data <= req_i.write_data;
      s1_q.pending_on <= req_i.pending_on;
    end
  end

  // Tag store
  msr_tag_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_set_i   (set_of(req_i.address)),
    .look_set_i (s1_q.set),
    .wr_i       (wr),
    .row_o      (row),
    .vld_o      (vld)
  );

  // Way lookup, lowest matching way wins
  always_comb begin
    any_hit = 1'b0;
    hit_way = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (vld[w] && row[w].tag == s1_q.tag) begin
        any_hit = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign hit_entry = row[hit_way];
  assign pmatch    = pend_active_q && pend_set_q == s1_q.set && pend_tag_q == s1_q.tag;

  // Response and state update
  always_comb begin
    sh_d          = 1'b0;
    mod_d         = 1'b0;
    ack_d         = 1'b0;
    dv_d          = 1'b0;
    rdata_d       = '0;
    wr            = '0;
    wr.set        = s1_q.set;
    pend_active_d = pend_active_q;
    pend_set_d    = pend_set_q;
    pend_tag_d    = pend_tag_q;
    pend_target_d = pend_target_q;

    unique case (s1_q.req_type)
      REQ_INSTALL: begin
        if ({3'b000, s1_q.way_sel} < WAY_LIMIT) begin
          wr.en          = 1'b1;
          wr.way         = WAY_W'(s1_q.way_sel);
          wr.entry.tag   = s1_q.tag;
          wr.entry.mesi  = s1_q.mesi_value;
          wr.entry.data  = s1_q.write_data;
          wr.valid       = (s1_q.mesi_value != MESI_I);
        end
      end
      REQ_PEND: begin
        pend_active_d = s1_q.pending_on;
        pend_set_d    = s1_q.set;
        pend_tag_d    = s1_q.tag;
        pend_target_d = s1_q.mesi_value;
      end
      REQ_SNOOP: begin
        if (pmatch) begin
          // answer from the pending record's future state
          sh_d  = (pend_target_q != MESI_I);
          mod_d = (pend_target_q == MESI_M);
          unique case (s1_q.bus_cmd)
            CMD_BUS_RDX: begin
              if (pend_target_q != MESI_I) begin
                pend_active_d = 1'b0;
                pend_target_d = MESI_I;
                ack_d         = 1'b1;
              end
            end
            CMD_BUS_RD: begin
              if (pend_target_q == MESI_E || pend_target_q == MESI_M) begin
                pend_target_d = MESI_S;
              end
            end
            CMD_BUS_UPGR: begin
              if (pend_target_q == MESI_S || pend_target_q == MESI_E) begin
                pend_active_d = 1'b0;
                pend_target_d = MESI_I;
                ack_d         = 1'b1;
              end
            end
            default: ;
          endcase
        end else if (any_hit) begin
          sh_d     = (hit_entry.mesi != MESI_I);
          mod_d    = (hit_entry.mesi == MESI_M);
          wr.way   = hit_way;
          wr.entry = hit_entry;
          unique case (s1_q.bus_cmd)
            CMD_BUS_RD: begin
              if (hit_entry.mesi == MESI_M) begin
                if (s1_q.data_grant) begin
                  rdata_d       = hit_entry.data;
                  dv_d          = 1'b1;
                  wr.en         = 1'b1;
                  wr.entry.mesi = MESI_S;
                  wr.valid      = 1'b1;
                end
              end else if (hit_entry.mesi == MESI_E) begin
                wr.en         = 1'b1;
                wr.entry.mesi = MESI_S;
                wr.valid      = 1'b1;
              end
            end
            CMD_BUS_RDX: begin
              if (hit_entry.mesi == MESI_M) begin
                if (s1_q.data_grant) begin
                  rdata_d       = hit_entry.data;
                  dv_d          = 1'b1;
                  wr.en         = 1'b1;
                  wr.entry.mesi = MESI_I;
                  wr.valid      = 1'b0;
                  ack_d         = 1'b1;
                end
              end else if (hit_entry.mesi != MESI_I) begin
                wr.en         = 1'b1;
                wr.entry.mesi = MESI_I;
                wr.valid      = 1'b0;
                ack_d         = 1'b1;
              end
            end
            CMD_BUS_UPGR: begin
              if (hit_entry.mesi == MESI_S || hit_entry.mesi == MESI_E) begin
                wr.en         = 1'b1;
                wr.entry.mesi = MESI_I;
                wr.valid      = 1'b0;
                ack_d         = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    wr.en = wr.en && s1_fire;
  end

  // Pending-miss record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_active_q <= 1'b0;
      pend_set_q    <= '0;
      pend_tag_q    <= '0;
      pend_target_q <= MESI_I;
    end else if (s1_fire) begin
      pend_active_q <= pend_active_d;
      pend_set_q    <= pend_set_d;
      pend_tag_q    <= pend_tag_d;
      pend_target_q <= pend_target_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      sh_q    <= sh_d;
      mod_q   <= mod_d;
      ack_q   <= ack_d;
      dv_q    <= dv_d;
      rdata_q <= rdata_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.line_held  = sh_q;
  assign rsp_o.has_mod    = mod_q;
  assign rsp_o.inv_ack    = ack_q;
  assign rsp_o.data_valid = dv_q;
  assign rsp_o.read_data  = rdata_q;

endmodule
`default_nettype wire
